[hdl/assert_macros.svh]
// ============================================================================
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk with active-low reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// ante at one edge implies cons at the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/bst_pkg.sv]
// ============================================================================
// bst_pkg
// Types, constants and character class helpers for the byte stream tokenizer.
// ============================================================================
package bst_pkg;

    localparam int MAX_INPUT_BYTES = 65536;
    localparam int POS_W           = $clog2(MAX_INPUT_BYTES + 1);
    localparam int FIELD_W         = 17;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_INPUT_BYTES);

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_IDENT = 3'd1;
    localparam logic [2:0] MODE_INT   = 3'd2;
    localparam logic [2:0] MODE_STR   = 3'd3;
    localparam logic [2:0] MODE_ERR   = 3'd4;

    localparam logic [4:0] K_PUNCT0 = 5'd7;
    localparam logic [4:0] K_IDENT  = 5'd5;
    localparam logic [4:0] K_INT    = 5'd6;
    localparam logic [4:0] K_STRING = 5'd19;
    localparam logic [4:0] K_EOF    = 5'd20;
    localparam logic [4:0] K_ERROR  = 5'd21;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN = 2'd1;
    localparam logic [1:0] ERR_UNTERM  = 2'd2;
    localparam logic [1:0] ERR_LONG    = 2'd3;

    localparam int NUM_KW    = 5;
    localparam int NUM_PUNCT = 12;

    localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
        '{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"m", "u", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"m", "a", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "r", "i", "n", "t", "l", "n", 8'h00}
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd2, 3'd3, 3'd3, 3'd4, 3'd7};

    localparam logic [7:0] PUNCT_TEXT [NUM_PUNCT] = '{
        "+", "-", "*", "/", "=", "(", ")", "{", "}", ";", "!", ","
    };

    typedef struct packed {
        logic [4:0]         kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic [1:0]         err;
        logic               last;
    } token_t;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_numeral(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

endpackage

[hdl/byte_stream_tokenizer.sv]
// ============================================================================
// byte_stream_tokenizer
// Streaming lexer: one source byte per transaction in, tokens out as kind,
// start offset and length.
// ============================================================================
// Accepts one byte or end-of-input transaction per cycle. Each transaction is
// captured in an input register and scanned from there, which pushes zero,
// one or two tokens into a four-entry output queue; the tokens show at the
// output as soon as they are in the queue. A captured transaction waits in the
// input register while the queue holds more than two tokens; in_ready drops
// only then, so a sustained rate of one transaction per cycle holds
// as long as the consumer takes one token per cycle. On any error a single
// error token is produced and further bytes are dropped until end of input;
// the consumer discards the tokens of that stream.
module byte_stream_tokenizer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             byte_value,
    input  logic                   end_of_input,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [4:0]             token_kind,
    output logic [bst_pkg::FIELD_W-1:0] token_start,
    output logic [bst_pkg::FIELD_W-1:0] token_length,
    output logic [1:0]             error_code,
    output logic                   last_of_item
);
    import bst_pkg::*;

    // input register
    logic             in_vld_reg;
    logic [7:0]       byte_reg;
    logic             eoi_reg;

    // scanner state
    logic [2:0]       mode_reg,  mode_next;
    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [POS_W-1:0] cstart_reg, cstart_next;
    logic [POS_W-1:0] clen_reg,  clen_next;
    logic [NUM_KW-1:0] kwc_reg,  kwc_next;

    // output queue
    token_t           q_mem [4];
    logic [1:0]       rd_ptr_reg, wr_ptr_reg;
    logic [2:0]       count_reg;

    logic             process;
    logic             pop;
    token_t           word_tok, main_tok, tok0, tok1;
    logic             word_emit, main_emit;
    logic [1:0]       push_n;

    assign process  = in_vld_reg && (count_reg <= 3'd2);
    assign in_ready = !in_vld_reg || process;
    assign pop      = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= byte_value;
            eoi_reg  <= end_of_input;
        end
    end

    // narrowed candidate set for byte b at identifier offset len
    function automatic logic [NUM_KW-1:0] narrow(input logic [NUM_KW-1:0] cand,
                                                 input logic [POS_W-1:0] len,
                                                 input logic [7:0] b);
        logic [NUM_KW-1:0] res;
        res = cand;
        for (int k = 0; k < NUM_KW; k++)
        begin
            if (len >= POS_W'(KW_LEN[k]) || KW_TEXT[k][len[2:0]] != b)
            begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic token_t make_tok(input logic [4:0] kind,
                                        input logic [POS_W-1:0] start,
                                        input logic [POS_W-1:0] len,
                                        input logic [1:0] err);
        token_t t;
        t.kind   = kind;
        t.start  = FIELD_W'(start);
        t.length = FIELD_W'(len);
        t.err    = err;
        t.last   = 1'b0;
        return t;
    endfunction

    always_comb
    begin
        logic [4:0] wkind;
        logic       is_punct;
        logic [4:0] pkind;
        logic       idle_scan;

        mode_next   = mode_reg;
        pos_next    = pos_reg;
        cstart_next = cstart_reg;
        clen_next   = clen_reg;
        kwc_next    = kwc_reg;
        word_emit   = 1'b0;
        main_emit   = 1'b0;
        idle_scan   = 1'b0;

        wkind = K_INT;
        if (mode_reg == MODE_IDENT)
        begin
            wkind = K_IDENT;
            for (int k = 0; k < NUM_KW; k++)
            begin
                if (kwc_reg[k] && clen_reg == POS_W'(KW_LEN[k]))
                begin
                    wkind = 5'(k);
                end
            end
        end
        word_tok = make_tok(wkind, cstart_reg, clen_reg, ERR_NONE);
        main_tok = make_tok(K_EOF, pos_reg, '0, ERR_NONE);

        is_punct = 1'b0;
        pkind    = K_PUNCT0;
        for (int i = 0; i < NUM_PUNCT; i++)
        begin
            if (PUNCT_TEXT[i] == byte_reg)
            begin
                is_punct = 1'b1;
                pkind    = K_PUNCT0 + 5'(i);
            end
        end

        if (eoi_reg)
        begin
            if (mode_reg == MODE_STR)
            begin
                main_emit = 1'b1;
                main_tok  = make_tok(K_ERROR, cstart_reg - 1'b1, '0, ERR_UNTERM);
            end
            else if (mode_reg != MODE_ERR)
            begin
                word_emit = (mode_reg == MODE_IDENT) || (mode_reg == MODE_INT);
                main_emit = 1'b1;
            end
            mode_next   = MODE_IDLE;
            pos_next    = '0;
            cstart_next = '0;
            clen_next   = '0;
            kwc_next    = '0;
        end
        else if (mode_reg != MODE_ERR)
        begin
            if (pos_reg == MAX_POS)
            begin
                main_emit = 1'b1;
                main_tok  = make_tok(K_ERROR, MAX_POS, '0, ERR_LONG);
                mode_next = MODE_ERR;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (mode_reg == MODE_STR)
                begin
                    if (byte_reg == "\"")
                    begin
                        main_emit = 1'b1;
                        main_tok  = make_tok(K_STRING, cstart_reg, clen_reg, ERR_NONE);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        clen_next = clen_reg + 1'b1;
                    end
                end
                else if (mode_reg == MODE_IDENT &&
                         (is_letter(byte_reg) || is_numeral(byte_reg) || byte_reg == "_"))
                begin
                    kwc_next  = narrow(kwc_reg, clen_reg, byte_reg);
                    clen_next = clen_reg + 1'b1;
                end
                else if (mode_reg == MODE_INT && is_numeral(byte_reg))
                begin
                    clen_next = clen_reg + 1'b1;
                end
                else
                begin
                    word_emit = (mode_reg == MODE_IDENT) || (mode_reg == MODE_INT);
                    mode_next = MODE_IDLE;
                    idle_scan = 1'b1;
                end
            end
        end

        if (idle_scan)
        begin
            priority if (is_space(byte_reg))
            begin
            end
            else if (is_letter(byte_reg))
            begin
                mode_next   = MODE_IDENT;
                cstart_next = pos_reg;
                kwc_next    = narrow('1, '0, byte_reg);
                clen_next   = POS_W'(1);
            end
            else if (is_numeral(byte_reg))
            begin
                mode_next   = MODE_INT;
                cstart_next = pos_reg;
                clen_next   = POS_W'(1);
            end
            else if (byte_reg == "\"")
            begin
                mode_next   = MODE_STR;
                cstart_next = pos_reg + 1'b1;
                clen_next   = '0;
            end
            else if (is_punct)
            begin
                main_emit = 1'b1;
                main_tok  = make_tok(pkind, pos_reg, POS_W'(1), ERR_NONE);
            end
            else
            begin
                main_emit = 1'b1;
                main_tok  = make_tok(K_ERROR, pos_reg, '0, ERR_UNKNOWN);
                mode_next = MODE_ERR;
            end
        end

        tok0   = word_emit ? word_tok : main_tok;
        tok1   = main_tok;
        push_n = 2'(word_emit) + 2'(main_emit);
        if (push_n == 2'd2)
        begin
            tok1.last = 1'b1;
        end
        else
        begin
            tok0.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            cstart_reg <= '0;
            clen_reg   <= '0;
            kwc_reg    <= '0;
        end
        else if (process)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            cstart_reg <= cstart_next;
            clen_reg   <= clen_next;
            kwc_reg    <= kwc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && push_n != 2'd0)
        begin
            q_mem[wr_ptr_reg] <= tok0;
        end
        if (process && push_n == 2'd2)
        begin
            q_mem[wr_ptr_reg + 2'd1] <= tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (process)
            begin
                wr_ptr_reg <= wr_ptr_reg + push_n;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (process ? 3'(push_n) : 3'd0) - 3'(pop);
        end
    end

    assign out_valid    = count_reg != 3'd0;
    assign token_kind   = q_mem[rd_ptr_reg].kind;
    assign token_start  = q_mem[rd_ptr_reg].start;
    assign token_length = q_mem[rd_ptr_reg].length;
    assign error_code   = q_mem[rd_ptr_reg].err;
    assign last_of_item = q_mem[rd_ptr_reg].last;

endmodule

[hdl/bst_checker.sv]
// ============================================================================
// bst_checker
// Port-level assertions for the byte stream tokenizer, bound to the top level.
// ============================================================================
`include "assert_macros.svh"

module bst_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [4:0]             token_kind,
    input logic [bst_pkg::FIELD_W-1:0] token_length,
    input logic [1:0]             error_code,
    input logic                   last_of_item
);
    import bst_pkg::*;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out_valid dropped before transaction")
    `ASSERT_ALWAYS(a_eof_last, clk, rst_n, !(out_valid && token_kind == K_EOF) || (last_of_item && token_length == '0), "eof token not last or nonzero length")
    `ASSERT_ALWAYS(a_err_form, clk, rst_n, !(out_valid && token_kind == K_ERROR) || (last_of_item && token_length == '0 && error_code != ERR_NONE), "malformed error token")
    `ASSERT_ALWAYS(a_code_none, clk, rst_n, !(out_valid && token_kind != K_ERROR) || error_code == ERR_NONE, "error code on non-error token")

endmodule

bind byte_stream_tokenizer bst_checker u_bst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_length (token_length),
    .error_code   (error_code),
    .last_of_item (last_of_item)
);

[test/byte_stream_tokenizer_tb.sv]
// ============================================================================
// byte_stream_tokenizer_tb
// Self-checking testbench for the streaming tokenizer. Source streams are
// sent byte by byte, each closed by an end-of-input transaction. A local
// lexer predicts the tokens, and every token taken from the block is compared
// field by field with the oldest prediction. Stimulus covers keywords,
// punctuation, strings, whitespace and error cases, under random idling,
// output back-pressure and a sender pause.
// ============================================================================
module byte_stream_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bst_pkg::*;

    localparam logic [4:0] K_KEYWORD0    = 5'd0;
    localparam logic [7:0] QUOTE         = 8'h22;
    localparam int         SEND_IDLE_PCT = 6;
    localparam int         SINK_IDLE_PCT = 6;
    localparam int         DRAIN_CYCLES  = 8;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_ready;
    logic [7:0]          byte_value   = 8'h00;
    logic                end_of_input = 1'b0;
    logic                out_valid;
    logic                out_ready    = 1'b0;
    logic [4:0]          token_kind;
    logic [FIELD_W-1:0]  token_start;
    logic [FIELD_W-1:0]  token_length;
    logic [1:0]          error_code;
    logic                last_of_item;

    string keyword_text [NUM_KW] = '{"fn", "let", "mut", "main", "println"};
    string punct_chars           = "+-*/=(){};!,";
    string blank_chars           = " \011\012\013\014\015";

    // lexer state for prediction
    logic [2:0] lex_mode;
    int         lex_pos;
    int         tok_start;
    int         tok_len;
    logic [4:0] kw_hits;

    token_t     expected_tokens [$];
    token_t     step_tokens [$];
    logic [7:0] stream_bytes [$];

    int failures     = 0;
    int items_sent   = 0;
    int hold_request = 0;
    bit calm         = 1'b0;

    byte_stream_tokenizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte_value   (byte_value),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .error_code   (error_code),
        .last_of_item (last_of_item)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit alpha_byte(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit digit_byte(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit blank_byte(input logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(1))
            return 8'("a" + $urandom_range(25));
        return 8'("A" + $urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_word_char();
        case ($urandom_range(3))
            0: return rand_letter();
            1: return rand_letter();
            2: return 8'("0" + $urandom_range(9));
            default: return "_";
        endcase
    endfunction

    task automatic append_byte(input logic [7:0] b);
        stream_bytes.insert(stream_bytes.size(), b);
    endtask

    task automatic reset_lexer();
        lex_mode  = MODE_IDLE;
        lex_pos   = 0;
        tok_start = 0;
        tok_len   = 0;
        kw_hits   = '0;
    endtask

    task automatic push_token(input logic [4:0] kind, input int start, input int len,
                              input logic [1:0] err);
        token_t t;
        t.kind   = kind;
        t.start  = FIELD_W'(start);
        t.length = FIELD_W'(len);
        t.err    = err;
        t.last   = 1'b0;
        step_tokens.insert(step_tokens.size(), t);
    endtask

    task automatic narrow_keywords(input logic [7:0] b);
        for (int k = 0; k < NUM_KW; k++)
            if (tok_len >= keyword_text[k].len() || 8'(keyword_text[k][tok_len]) != b)
                kw_hits[k] = 1'b0;
    endtask

    task automatic close_word();
        logic [4:0] kind;
        kind = K_INT;
        if (lex_mode == MODE_IDENT)
        begin
            kind = K_IDENT;
            for (int k = 0; k < NUM_KW; k++)
                if (kw_hits[k] && tok_len == keyword_text[k].len())
                    kind = K_KEYWORD0 + 5'(k);
        end
        push_token(kind, tok_start, tok_len, ERR_NONE);
        lex_mode = MODE_IDLE;
    endtask

    task automatic scan_from_idle(input logic [7:0] b);
        int p;
        p = -1;
        for (int i = 0; i < punct_chars.len(); i++)
            if (8'(punct_chars[i]) == b)
                p = i;
        if (blank_byte(b))
        begin
        end
        else if (alpha_byte(b))
        begin
            lex_mode  = MODE_IDENT;
            tok_start = lex_pos;
            tok_len   = 0;
            kw_hits   = 5'h1F;
            narrow_keywords(b);
            tok_len   = 1;
        end
        else if (digit_byte(b))
        begin
            lex_mode  = MODE_INT;
            tok_start = lex_pos;
            tok_len   = 1;
        end
        else if (b == QUOTE)
        begin
            lex_mode  = MODE_STR;
            tok_start = lex_pos + 1;
            tok_len   = 0;
        end
        else if (p >= 0)
            push_token(K_PUNCT0 + 5'(p), lex_pos, 1, ERR_NONE);
        else
        begin
            push_token(K_ERROR, lex_pos, 0, ERR_UNKNOWN);
            lex_mode = MODE_ERR;
        end
    endtask

    task automatic predict_item(input logic [7:0] b, input logic eoi);
        step_tokens.delete();
        if (eoi)
        begin
            if (lex_mode == MODE_STR)
                push_token(K_ERROR, tok_start - 1, 0, ERR_UNTERM);
            else if (lex_mode != MODE_ERR)
            begin
                if (lex_mode == MODE_IDENT || lex_mode == MODE_INT)
                    close_word();
                push_token(K_EOF, lex_pos, 0, ERR_NONE);
            end
            reset_lexer();
        end
        else if (lex_mode != MODE_ERR)
        begin
            if (lex_pos >= MAX_INPUT_BYTES)
            begin
                push_token(K_ERROR, MAX_INPUT_BYTES, 0, ERR_LONG);
                lex_mode = MODE_ERR;
            end
            else
            begin
                if (lex_mode == MODE_STR)
                begin
                    if (b == QUOTE)
                    begin
                        push_token(K_STRING, tok_start, tok_len, ERR_NONE);
                        lex_mode = MODE_IDLE;
                    end
                    else
                        tok_len++;
                end
                else if (lex_mode == MODE_IDENT && (alpha_byte(b) || digit_byte(b) || b == "_"))
                begin
                    narrow_keywords(b);
                    tok_len++;
                end
                else if (lex_mode == MODE_INT && digit_byte(b))
                    tok_len++;
                else
                begin
                    if (lex_mode == MODE_IDENT || lex_mode == MODE_INT)
                        close_word();
                    scan_from_idle(b);
                end
                lex_pos++;
            end
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        while (step_tokens.size() > 0)
            expected_tokens.insert(expected_tokens.size(), step_tokens.pop_front());
    endtask

    // one input transaction; prediction runs at the accepting edge
    task automatic send_item(input logic [7:0] b, input logic eoi);
        bit taken;
        if (!calm && $urandom_range(99) < SEND_IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        byte_value   <= b;
        end_of_input <= eoi;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        items_sent++;
        predict_item(b, eoi);
    endtask

    task automatic send_eof();
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(8'(s[i]), 1'b0);
    endtask

    task automatic send_stream();
        foreach (stream_bytes[i])
            send_item(stream_bytes[i], 1'b0);
        send_eof();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_tokens.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic append_separator();
        if ($urandom_range(1))
            append_byte(8'(blank_chars[$urandom_range(blank_chars.len() - 1)]));
        else
            append_byte(8'(punct_chars[$urandom_range(punct_chars.len() - 1)]));
    endtask

    task automatic append_fragment(input bit allow_noise);
        int         pick;
        int         n;
        logic [7:0] c;
        bit         word;
        pick = $urandom_range(99);
        word = 1'b0;
        if (pick < 15)
        begin
            n = $urandom_range(NUM_KW - 1);
            for (int i = 0; i < keyword_text[n].len(); i++)
                append_byte(8'(keyword_text[n][i]));
            case ($urandom_range(5))
                0: void'(stream_bytes.pop_back());
                1: append_byte(rand_word_char());
                default: ;
            endcase
            word = 1'b1;
        end
        else if (pick < 35)
        begin
            append_byte(rand_letter());
            repeat ($urandom_range(8)) append_byte(rand_word_char());
            word = 1'b1;
        end
        else if (pick < 50)
        begin
            repeat ($urandom_range(6, 1)) append_byte(8'("0" + $urandom_range(9)));
            word = 1'b1;
        end
        else if (pick < 70)
            append_byte(8'(punct_chars[$urandom_range(punct_chars.len() - 1)]));
        else if (pick < 80)
        begin
            append_byte(QUOTE);
            repeat ($urandom_range(10))
            begin
                do
                    c = 8'($urandom_range(255));
                while (c == QUOTE);
                append_byte(c);
            end
            append_byte(QUOTE);
        end
        else if (pick < 99 || !allow_noise)
        begin
            repeat ($urandom_range(3, 1))
                append_byte(8'(blank_chars[$urandom_range(blank_chars.len() - 1)]));
        end
        else
            append_byte(8'($urandom_range(255)));
        if (word && $urandom_range(9) < 7)
            append_separator();
    endtask

    task automatic test_directed();
        send_text("fn;let(mut)main{println}-*/=!,+");
        send_eof();
        // all six blanks, ident cut by punctuation, integer open at end of input
        send_text("\011\012\013\014\015 Zz_9+0");
        send_eof();
        // integer cut by a high byte; later bytes ignored
        send_item("7", 1'b0);
        send_item(8'h80, 1'b0);
        send_item("q", 1'b0);
        send_eof();
        send_text("\"\"\"ab");
        send_eof();
        send_item(8'hFF, 1'b0);
        send_eof();
        send_item(8'h00, 1'b0);
        send_eof();
        send_item("_", 1'b0);
        send_eof();
        send_eof();
    endtask

    task automatic test_backpressure();
        calm = 1'b1;
        hold_request = 150;
        repeat (60) send_item(8'(punct_chars[$urandom_range(punct_chars.len() - 1)]), 1'b0);
        send_eof();
        calm = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_streams(input int quota);
        int goal;
        int stream_idx;
        goal = items_sent + quota;
        stream_idx = 0;
        while (items_sent < goal)
        begin
            calm = (stream_idx >= 20 && stream_idx < 35);
            stream_bytes.delete();
            repeat ($urandom_range(30, 1)) append_fragment(1'b1);
            if ($urandom_range(19) == 0)
            begin
                append_byte(QUOTE);
                repeat ($urandom_range(3)) append_byte(rand_word_char());
            end
            send_stream();
            if (stream_idx == 10)
                wait_drained();
            stream_idx++;
        end
        calm = 1'b0;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            failures++;
            $display("%0t %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(negedge clk)
    begin
        token_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_tokens.size() == 0)
            begin
                failures++;
                $display("%0t token expected none actual kind %0d start %0d",
                         $time, token_kind, token_start);
            end
            else
            begin
                want = expected_tokens.pop_front();
                check_field("token_kind", want.kind, token_kind);
                check_field("token_start", want.start, token_start);
                check_field("token_length", want.length, token_length);
                check_field("error_code", want.err, error_code);
                check_field("last_of_item", want.last, last_of_item);
            end
        end
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= calm || $urandom_range(99) >= SINK_IDLE_PCT;
        end
    end

    initial
    begin
        reset_lexer();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random_streams(1300);
        wait_drained();
        if (failures == 0)
            $display("[byte_stream_tokenizer] OK");
        else
            $display("[byte_stream_tokenizer] ERROR");
        $finish;
    end

    initial
    begin
        #200_000;
        $display("[byte_stream_tokenizer] ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/bst_pkg.sv
hdl/byte_stream_tokenizer.sv
hdl/bst_checker.sv
test/byte_stream_tokenizer_tb.sv
